[sv/rthsv_pkg.sv]
// ----------------------------------------------------------------------------
// rthsv_pkg
// Shared constants, types and codes of the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rthsv_pkg;

    // default width of one color component
    localparam int COMPONENT_BITS_DEF = 8;

    // hue is given in 1/64 degree
    localparam int HUE_BITS     = 15;
    localparam int SECTOR_UNITS = 3840;   // 60 degrees
    localparam int CIRCLE_UNITS = 23040;  // 360 degrees

    // sector of the largest component
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // control bits that travel with each pipeline stage
    typedef struct packed {
        logic valid;
        logic undef;
    } t_ctl;

endpackage

`default_nettype wire

[sv/rthsv_rgb_if.sv]
// ----------------------------------------------------------------------------
// rthsv_rgb_if
// Valid/ready channel carrying one RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rthsv_rgb_if
    import rthsv_pkg::*;
#(
    parameter int COMP_BITS = COMPONENT_BITS_DEF
) ();

    logic                 valid;
    logic                 ready;
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

[sv/rthsv_hsv_if.sv]
// ----------------------------------------------------------------------------
// rthsv_hsv_if
// Valid/ready channel carrying one HSV result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rthsv_hsv_if
    import rthsv_pkg::*;
#(
    parameter int COMP_BITS = COMPONENT_BITS_DEF
) ();

    logic                 valid;
    logic                 ready;
    logic [HUE_BITS-1:0]  hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] brightness;
    logic                 hue_undefined;

    modport source (
        output valid, output hue, output saturation, output brightness,
        output hue_undefined, input ready
    );
    modport sink (
        input valid, input hue, input saturation, input brightness,
        input hue_undefined, output ready
    );

endinterface

`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Fixed-point RGB to HSV, fully pipelined, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  i_pix     in    valid / ready   red, green, blue
//  o_hsv     out   valid / ready   hue, saturation, brightness, hue_undefined
//
//  pipeline: front end, then the restoring divider chain, one quotient bit
//  per stage; every stage is a register with its valid bit
//  throughput: one pixel per clock unless o_hsv stalls
//  reset clears only the valid and undef bits, the pipeline is empty afterwards
//  a stall on o_hsv propagates back through full stages, empty stages still fill
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter
    import rthsv_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rthsv_rgb_if.sink     i_pix,
    rthsv_hsv_if.source   o_hsv
);

    localparam int N  = COMPONENT_BITS;
    localparam int QB = (HUE_BITS > N) ? HUE_BITS : N;
    localparam int RW = N + QB;

    // links between stages, link 0 leaves the front end
    t_ctl          s_ctl     [QB+1];
    logic          s_rdy     [QB+1];
    logic [RW-1:0] s_hue_rem [QB+1];
    logic [QB-1:0] s_hue_q   [QB+1];
    logic [RW-1:0] s_sat_rem [QB+1];
    logic [QB-1:0] s_sat_q   [QB+1];
    logic [N-1:0]  s_d       [QB+1];
    logic [N-1:0]  s_hi      [QB+1];

    // max, sector and numerators
    rthsv_front #(
        .N  (N),
        .RW (RW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_red     (i_pix.red),
        .i_green   (i_pix.green),
        .i_blue    (i_pix.blue),
        .o_ctl     (s_ctl[0]),
        .i_ready   (s_rdy[0]),
        .o_hue_num (s_hue_rem[0]),
        .o_sat_num (s_sat_rem[0]),
        .o_d       (s_d[0]),
        .o_hi      (s_hi[0])
    );

    assign s_hue_q[0] = '0;
    assign s_sat_q[0] = '0;

    // divider chain, most significant quotient bit first
    for (genvar j = 0; j < QB; j++) begin : g_div
        rthsv_div_stage #(
            .N  (N),
            .QB (QB),
            .RW (RW),
            .K  (QB - 1 - j)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (s_ctl[j]),
            .o_ready   (s_rdy[j]),
            .i_hue_rem (s_hue_rem[j]),
            .i_hue_q   (s_hue_q[j]),
            .i_sat_rem (s_sat_rem[j]),
            .i_sat_q   (s_sat_q[j]),
            .i_d       (s_d[j]),
            .i_hi      (s_hi[j]),
            .o_ctl     (s_ctl[j+1]),
            .i_ready   (s_rdy[j+1]),
            .o_hue_rem (s_hue_rem[j+1]),
            .o_hue_q   (s_hue_q[j+1]),
            .o_sat_rem (s_sat_rem[j+1]),
            .o_sat_q   (s_sat_q[j+1]),
            .o_d       (s_d[j+1]),
            .o_hi      (s_hi[j+1])
        );
    end

    // output, undefined hue and black saturation forced to zero
    assign s_rdy[QB]           = o_hsv.ready;
    assign o_hsv.valid         = s_ctl[QB].valid;
    assign o_hsv.hue_undefined = s_ctl[QB].undef;
    assign o_hsv.brightness    = s_hi[QB];
    assign o_hsv.hue           = s_ctl[QB].undef ? '0 : s_hue_q[QB][HUE_BITS-1:0];
    assign o_hsv.saturation    = (s_hi[QB] == '0) ? '0 : s_sat_q[QB][N-1:0];

    // hue stays inside one circle
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid |-> (32'(o_hsv.hue) < 32'(CIRCLE_UNITS)))
        else $error("hue out of range");

    // undefined hue comes with zero saturation
    a_undef_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.hue_undefined) |-> (o_hsv.saturation == '0))
        else $error("undefined hue with nonzero saturation");

    // black is always flagged
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.brightness == '0) |-> o_hsv.hue_undefined)
        else $error("black pixel without undefined hue flag");

endmodule

`default_nettype wire

[sv/rthsv_front.sv]
// ----------------------------------------------------------------------------
// rthsv_front
// Two front stages: max/min/sector search, then the hue and saturation
// numerators that feed the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rthsv_front
    import rthsv_pkg::*;
#(
    parameter int N  = COMPONENT_BITS_DEF,
    parameter int RW = N + HUE_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // pixel in
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [N-1:0]  i_red,
    input  wire logic [N-1:0]  i_green,
    input  wire logic [N-1:0]  i_blue,
    // numerators out
    output t_ctl               o_ctl,
    input  wire logic          i_ready,
    output logic [RW-1:0]      o_hue_num,
    output logic [RW-1:0]      o_sat_num,
    output logic [N-1:0]       o_d,
    output logic [N-1:0]       o_hi
);

    localparam int SW = RW + 1;
    localparam logic signed [13:0]    SEC_S     = 14'(SECTOR_UNITS);
    localparam logic [HUE_BITS-1:0]   OFF_WRAP  = HUE_BITS'(CIRCLE_UNITS);
    localparam logic [HUE_BITS-1:0]   OFF_GREEN = HUE_BITS'(2 * SECTOR_UNITS);
    localparam logic [HUE_BITS-1:0]   OFF_BLUE  = HUE_BITS'(4 * SECTOR_UNITS);

    // stage a registers
    t_ctl                r_a_ctl;
    t_sector             r_a_sec;
    logic [N-1:0]        r_a_hi;
    logic [N-1:0]        r_a_d;
    logic signed [N:0]   r_a_diff;

    // stage b registers
    t_ctl                r_b_ctl;
    logic [RW-1:0]       r_b_hue_num;
    logic [RW-1:0]       r_b_sat_num;
    logic [N-1:0]        r_b_d;
    logic [N-1:0]        r_b_hi;

    t_sector             n_a_sec;
    logic [N-1:0]        n_a_hi;
    logic [N-1:0]        n_a_lo;
    logic signed [N:0]   n_a_diff;

    logic                w_a_ready;
    logic                w_b_ready;

    logic [HUE_BITS-1:0]   w_offset;
    logic [HUE_BITS+N-1:0] w_off_prod;
    logic signed [N+14:0]  w_diff_prod;
    logic signed [SW-1:0]  w_num;
    logic [RW-1:0]         w_sat_num;

    // stage handshake, a stage loads when empty or when it drains
    assign w_b_ready = !r_b_ctl.valid || i_ready;
    assign w_a_ready = !r_a_ctl.valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // largest component with red over green over blue on ties
    always_comb begin
        n_a_sec = SEC_BLUE;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sec = SEC_RED;
        end else if (i_green >= i_blue) begin
            n_a_sec = SEC_GREEN;
        end
        case (n_a_sec)
            SEC_RED: begin
                n_a_hi   = i_red;
                n_a_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            end
            SEC_GREEN: begin
                n_a_hi   = i_green;
                n_a_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            end
            default: begin
                n_a_hi   = i_blue;
                n_a_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            end
        endcase
    end

    // smallest component
    always_comb begin
        n_a_lo = (i_red < i_green) ? i_red : i_green;
        if (i_blue < n_a_lo) begin
            n_a_lo = i_blue;
        end
    end

    // stage a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (w_a_ready) begin
            r_a_ctl.valid <= i_valid;
            r_a_ctl.undef <= (n_a_hi == n_a_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_sec  <= n_a_sec;
            r_a_hi   <= n_a_hi;
            r_a_d    <= n_a_hi - n_a_lo;
            r_a_diff <= n_a_diff;
        end
    end

    // sector offset, red with a negative spread wraps by a full circle
    always_comb begin
        case (r_a_sec)
            SEC_RED:   w_offset = (r_a_diff < 0) ? OFF_WRAP : '0;
            SEC_GREEN: w_offset = OFF_GREEN;
            default:   w_offset = OFF_BLUE;
        endcase
    end

    // hue numerator offset*d + 3840*diff, never negative
    assign w_off_prod  = w_offset * r_a_d;
    assign w_diff_prod = (N+15)'(r_a_diff) * (N+15)'(SEC_S);
    assign w_num       = SW'($signed({1'b0, w_off_prod})) + SW'(w_diff_prod);

    // saturation numerator d * full scale
    assign w_sat_num = (RW'(r_a_d) << N) - RW'(r_a_d);

    // stage b
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (w_b_ready) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_ctl.valid) begin
            r_b_hue_num <= w_num[RW-1:0];
            r_b_sat_num <= w_sat_num;
            r_b_d       <= r_a_d;
            r_b_hi      <= r_a_hi;
        end
    end

    assign o_ctl     = r_b_ctl;
    assign o_hue_num = r_b_hue_num;
    assign o_sat_num = r_b_sat_num;
    assign o_d       = r_b_d;
    assign o_hi      = r_b_hi;

endmodule

`default_nettype wire

[sv/rthsv_div_stage.sv]
// ----------------------------------------------------------------------------
// rthsv_div_stage
// One restoring division step for hue and saturation: decides quotient
// bit K of both quotients and registers the partial remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module rthsv_div_stage
    import rthsv_pkg::*;
#(
    parameter int N  = COMPONENT_BITS_DEF,
    parameter int QB = HUE_BITS,
    parameter int RW = N + QB,
    parameter int K  = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // upstream
    input  wire t_ctl           i_ctl,
    output logic                o_ready,
    input  wire logic [RW-1:0]  i_hue_rem,
    input  wire logic [QB-1:0]  i_hue_q,
    input  wire logic [RW-1:0]  i_sat_rem,
    input  wire logic [QB-1:0]  i_sat_q,
    input  wire logic [N-1:0]   i_d,
    input  wire logic [N-1:0]   i_hi,
    // downstream
    output t_ctl                o_ctl,
    input  wire logic           i_ready,
    output logic [RW-1:0]       o_hue_rem,
    output logic [QB-1:0]       o_hue_q,
    output logic [RW-1:0]       o_sat_rem,
    output logic [QB-1:0]       o_sat_q,
    output logic [N-1:0]        o_d,
    output logic [N-1:0]        o_hi
);

    t_ctl           r_ctl;
    logic [RW-1:0]  r_hue_rem;
    logic [QB-1:0]  r_hue_q;
    logic [RW-1:0]  r_sat_rem;
    logic [QB-1:0]  r_sat_q;
    logic [N-1:0]   r_d;
    logic [N-1:0]   r_hi;

    logic [RW-1:0]  w_hue_sub;
    logic [RW-1:0]  w_sat_sub;
    logic           w_hue_ge;
    logic           w_sat_ge;
    logic [RW-1:0]  n_hue_rem;
    logic [QB-1:0]  n_hue_q;
    logic [RW-1:0]  n_sat_rem;
    logic [QB-1:0]  n_sat_q;

    assign o_ready = !r_ctl.valid || i_ready;

    // compare against the divisor shifted to this bit
    assign w_hue_sub = RW'(i_d) << K;
    assign w_sat_sub = RW'(i_hi) << K;
    assign w_hue_ge  = (i_hue_rem >= w_hue_sub);
    assign w_sat_ge  = (i_sat_rem >= w_sat_sub);

    always_comb begin
        n_hue_rem = w_hue_ge ? (i_hue_rem - w_hue_sub) : i_hue_rem;
        n_sat_rem = w_sat_ge ? (i_sat_rem - w_sat_sub) : i_sat_rem;
        n_hue_q    = i_hue_q;
        n_sat_q    = i_sat_q;
        n_hue_q[K] = w_hue_ge;
        n_sat_q[K] = w_sat_ge;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_hue_rem <= n_hue_rem;
            r_hue_q   <= n_hue_q;
            r_sat_rem <= n_sat_rem;
            r_sat_q   <= n_sat_q;
            r_d       <= i_d;
            r_hi      <= i_hi;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_q   = r_hue_q;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_q   = r_sat_q;
    assign o_d       = r_d;
    assign o_hi      = r_hi;

    // a held transaction keeps its quotients while stalled
    a_hold_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.valid && !i_ready) |=> ($stable(r_hue_q) && $stable(r_sat_q)
            && r_ctl.valid))
        else $error("division stage lost its transaction during a stall");

    // hue remainder stays below the divisor once the last bit is decided
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.valid && !r_ctl.undef && K == 0) |-> (r_hue_rem < RW'(r_d)))
        else $error("hue remainder not reduced below the spread");

endmodule

`default_nettype wire
